[rtl/jpp_pkg.sv]
`timescale 1ns / 1ps

package jpp_pkg;

    localparam int INDENT_STEP_DEF = 4;
    localparam int DEPTH_LIMIT_DEF = 16;

    localparam int BYTE_W  = 8;
    localparam int IND_W   = 7;
    localparam int LEVEL_W = 5;
    localparam int MAX_RES = 3;
    localparam int QDEPTH  = 4;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic KIND_LIT = 1'b0;
    localparam logic KIND_NL  = 1'b1;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_OPENED = 3'd1,
        MODE_STRING = 3'd2,
        MODE_ESCAPE = 3'd3,
        MODE_TOKEN  = 3'd4
    } t_mode;

    typedef struct packed {
        logic             kind;
        logic [7:0]       out_byte;
        logic [IND_W-1:0] indent_spaces;
        logic             last_of_run;
    } t_rec;

    typedef struct packed {
        t_mode            mode;
        logic [IND_W-1:0] indent;
        logic [1:0]       count;
    } t_step;

    // indent ceiling, limited to what the indent field holds
    function automatic int indent_cap(input int depth, input int step);
        int raw;
        raw = depth * step;
        return (raw > 127) ? 127 : raw;
    endfunction

endpackage

[rtl/jpp_in_if.sv]
`timescale 1ns / 1ps

interface jpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_doc;

    modport source (output valid, output in_byte, output end_of_doc, input ready);
    modport sink   (input valid, input in_byte, input end_of_doc, output ready);
endinterface

[rtl/jpp_out_if.sv]
`timescale 1ns / 1ps

interface jpp_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;
    logic [6:0] indent_spaces;
    logic       last_of_run;

    modport source (output valid, output kind, output out_byte, output indent_spaces,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input out_byte, input indent_spaces,
                    input last_of_run, output ready);
endinterface

[rtl/jpp_cfg_if.sv]
`timescale 1ns / 1ps

interface jpp_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] start_level;

    modport source (output valid, output start_level, input ready);
    modport sink   (input valid, input start_level, output ready);
endinterface

[rtl/json_pretty_printer.sv]
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// i_in      in   valid/ready    in_byte[7:0], end_of_doc
// o_out     out  valid/ready    kind, out_byte[7:0], indent_spaces[6:0], last_of_run
// i_cfg     in   valid/ready    start_level[4:0] (ready always high)
//
// one byte is accepted per cycle while the result queue holds at most one entry;
// each byte turns into zero to three results that enter the queue at the edge that
// accepts it, behind any result still waiting there
// results leave the four-entry queue one per cycle while the output is ready, so bytes with
// two or three results hold the input until the queue is back down to one entry
// reset is synchronous and active low; the indent
// starts at zero until a start level is written

module json_pretty_printer #(
    parameter int INDENT_STEP = jpp_pkg::INDENT_STEP_DEF,
    parameter int DEPTH_LIMIT = jpp_pkg::DEPTH_LIMIT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jpp_in_if.sink           i_in,
    jpp_out_if.source        o_out,
    jpp_cfg_if.sink          i_cfg
);

    localparam int CAP = jpp_pkg::indent_cap(DEPTH_LIMIT, INDENT_STEP);
    localparam logic [8:0] CAP_9 = 9'(CAP);

    jpp_pkg::t_mode            r_mode;
    logic [jpp_pkg::IND_W-1:0] r_indent;
    logic [jpp_pkg::IND_W-1:0] r_start_indent;
    logic [2:0]                r_cnt, n_cnt;
    jpp_pkg::t_rec [jpp_pkg::QDEPTH-1:0] r_q, n_q;

    jpp_pkg::t_rec [jpp_pkg::MAX_RES-1:0] rec;
    jpp_pkg::t_step            step;

    logic                      in_acc, cfg_acc, pop;
    logic [2:0]                rem;
    logic [8:0]                cfg_prod;
    logic [jpp_pkg::IND_W-1:0] cfg_indent;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;
    assign cfg_prod    = 9'(i_cfg.start_level) * 9'(INDENT_STEP);
    assign cfg_indent  = (cfg_prod > CAP_9) ? jpp_pkg::IND_W'(CAP)
                                            : cfg_prod[jpp_pkg::IND_W-1:0];

    // room for a full three-result burst behind one waiting result
    assign i_in.ready = (r_cnt <= 3'd1);
    assign in_acc     = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;

    jpp_format #(
        .INDENT_STEP (INDENT_STEP),
        .DEPTH_LIMIT (DEPTH_LIMIT)
    ) u_format (
        .i_byte         (i_in.in_byte),
        .i_eod          (i_in.end_of_doc),
        .i_mode         (r_mode),
        .i_indent       (r_indent),
        .i_start_indent (r_start_indent),
        .o_rec          (rec),
        .o_step         (step)
    );

    assign rem   = r_cnt - {2'b00, pop};
    assign n_cnt = rem + (in_acc ? {1'b0, step.count} : 3'd0);

    always_comb begin
        int k;
        k   = 0;
        n_q = pop ? (r_q >> $bits(jpp_pkg::t_rec)) : r_q;
        for (int i = 0; i < jpp_pkg::QDEPTH; i++) begin
            k = i - int'(rem);
            if (in_acc && (k >= 0) && (k < int'(step.count))) begin
                n_q[i] = rec[2'(k)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= jpp_pkg::MODE_NORMAL;
            r_indent       <= '0;
            r_start_indent <= '0;
            r_cnt          <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (cfg_acc) begin
                r_start_indent <= cfg_indent;
                r_indent       <= cfg_indent;
                r_mode         <= jpp_pkg::MODE_NORMAL;
            end else if (in_acc) begin
                r_mode   <= step.mode;
                r_indent <= step.indent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_out.valid         = (r_cnt != 3'd0);
    assign o_out.kind          = r_q[0].kind;
    assign o_out.out_byte      = r_q[0].out_byte;
    assign o_out.indent_spaces = r_q[0].indent_spaces;
    assign o_out.last_of_run   = r_q[0].last_of_run;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(jpp_pkg::QDEPTH))
        else $error("result queue overfilled");

    a_indent_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_indent <= jpp_pkg::IND_W'(CAP))
        else $error("indent above its ceiling");

    // the rest of a byte's results always sit in the queue behind its head
    a_run_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !r_q[0].last_of_run) |-> (r_cnt >= 3'd2))
        else $error("result run split");

    a_burst_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !pop) |=> (r_cnt == $past(r_cnt) + {1'b0, $past(step.count)}))
        else $error("queue count lost a result");

endmodule

[rtl/jpp_format.sv]
`timescale 1ns / 1ps

module jpp_format #(
    parameter int INDENT_STEP = jpp_pkg::INDENT_STEP_DEF,
    parameter int DEPTH_LIMIT = jpp_pkg::DEPTH_LIMIT_DEF
) (
    input  logic [7:0]                          i_byte,
    input  logic                                i_eod,
    input  jpp_pkg::t_mode                      i_mode,
    input  logic [jpp_pkg::IND_W-1:0]           i_indent,
    input  logic [jpp_pkg::IND_W-1:0]           i_start_indent,
    output jpp_pkg::t_rec [jpp_pkg::MAX_RES-1:0] o_rec,
    output jpp_pkg::t_step                      o_step
);

    localparam int CAP = jpp_pkg::indent_cap(DEPTH_LIMIT, INDENT_STEP);
    localparam logic [jpp_pkg::IND_W:0]   CAP_W  = (jpp_pkg::IND_W+1)'(CAP);
    localparam logic [jpp_pkg::IND_W-1:0] STEP_N = jpp_pkg::IND_W'(INDENT_STEP);

    function automatic jpp_pkg::t_rec lit(input logic [7:0] c);
        jpp_pkg::t_rec r;
        r.kind          = jpp_pkg::KIND_LIT;
        r.out_byte      = c;
        r.indent_spaces = '0;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    function automatic jpp_pkg::t_rec nl(input logic [jpp_pkg::IND_W-1:0] ind);
        jpp_pkg::t_rec r;
        r.kind          = jpp_pkg::KIND_NL;
        r.out_byte      = jpp_pkg::CH_LF;
        r.indent_spaces = ind;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    logic is_ws4, is_ws6, is_closer, is_opener;
    logic [jpp_pkg::IND_W:0]   up_sum;
    logic [jpp_pkg::IND_W-1:0] ind_up, ind_n, ind_down;

    jpp_pkg::t_rec             nm_rec0, nm_rec1;
    logic [1:0]                nm_cnt;
    jpp_pkg::t_mode            nm_mode;
    logic [jpp_pkg::IND_W-1:0] nm_ind;

    jpp_pkg::t_rec [jpp_pkg::MAX_RES-1:0] rec;
    logic [1:0]                cnt;
    jpp_pkg::t_mode            mode;
    logic [jpp_pkg::IND_W-1:0] ind;

    assign is_ws4    = (i_byte == jpp_pkg::CH_SPACE) || (i_byte == jpp_pkg::CH_CR) ||
                       (i_byte == jpp_pkg::CH_LF) || (i_byte == jpp_pkg::CH_TAB);
    assign is_ws6    = is_ws4 || (i_byte == jpp_pkg::CH_VT) || (i_byte == jpp_pkg::CH_FF);
    assign is_closer = (i_byte == jpp_pkg::CH_RBRACK) || (i_byte == jpp_pkg::CH_RBRACE);
    assign is_opener = (i_byte == jpp_pkg::CH_LBRACK) || (i_byte == jpp_pkg::CH_LBRACE);

    assign up_sum   = {1'b0, i_indent} + {1'b0, STEP_N};
    assign ind_up   = (up_sum > CAP_W) ? jpp_pkg::IND_W'(CAP) : up_sum[jpp_pkg::IND_W-1:0];
    // a byte after an opener is handled at the raised indent
    assign ind_n    = (i_mode == jpp_pkg::MODE_OPENED) ? ind_up : i_indent;
    assign ind_down = (ind_n >= STEP_N) ? (ind_n - STEP_N) : ind_n;

    // byte handling outside strings and tokens
    always_comb begin
        nm_rec0 = lit(i_byte);
        nm_rec1 = lit(jpp_pkg::CH_SPACE);
        nm_cnt  = 2'd1;
        nm_mode = jpp_pkg::MODE_NORMAL;
        nm_ind  = ind_n;
        priority if (is_ws4) begin
            nm_cnt = 2'd0;
        end else if (is_opener) begin
            nm_mode = jpp_pkg::MODE_OPENED;
        end else if (i_byte == jpp_pkg::CH_COMMA) begin
            nm_rec1 = nl(ind_n);
            nm_cnt  = 2'd2;
        end else if (i_byte == jpp_pkg::CH_COLON) begin
            nm_cnt = 2'd2;
        end else if (is_closer) begin
            nm_ind  = ind_down;
            nm_rec0 = nl(ind_down);
            nm_rec1 = lit(i_byte);
            nm_cnt  = 2'd2;
        end else if (i_byte == jpp_pkg::CH_QUOTE) begin
            nm_mode = jpp_pkg::MODE_STRING;
        end else begin
            nm_mode = jpp_pkg::MODE_TOKEN;
        end
    end

    always_comb begin
        rec  = '0;
        cnt  = 2'd0;
        mode = i_mode;
        ind  = i_indent;
        unique case (i_mode)
            jpp_pkg::MODE_OPENED: begin
                if (is_ws6) begin
                    cnt = 2'd0;
                end else if (is_closer) begin
                    // empty pair stays on one line
                    rec[0] = lit(i_byte);
                    cnt    = 2'd1;
                    mode   = jpp_pkg::MODE_NORMAL;
                end else begin
                    rec[0] = nl(ind_up);
                    rec[1] = nm_rec0;
                    rec[2] = nm_rec1;
                    cnt    = nm_cnt + 2'd1;
                    mode   = nm_mode;
                    ind    = nm_ind;
                end
            end
            jpp_pkg::MODE_STRING: begin
                rec[0] = lit(i_byte);
                cnt    = 2'd1;
                if (i_byte == jpp_pkg::CH_QUOTE) begin
                    mode = jpp_pkg::MODE_NORMAL;
                end else if (i_byte == jpp_pkg::CH_BSLASH) begin
                    mode = jpp_pkg::MODE_ESCAPE;
                end
            end
            jpp_pkg::MODE_ESCAPE: begin
                rec[0] = lit(i_byte);
                cnt    = 2'd1;
                mode   = jpp_pkg::MODE_STRING;
            end
            jpp_pkg::MODE_TOKEN: begin
                if (is_closer || is_ws4 || (i_byte == jpp_pkg::CH_COMMA)) begin
                    rec[0] = nm_rec0;
                    rec[1] = nm_rec1;
                    cnt    = nm_cnt;
                    mode   = nm_mode;
                    ind    = nm_ind;
                end else begin
                    rec[0] = lit(i_byte);
                    cnt    = 2'd1;
                end
            end
            default: begin
                rec[0] = nm_rec0;
                rec[1] = nm_rec1;
                cnt    = nm_cnt;
                mode   = nm_mode;
                ind    = nm_ind;
            end
        endcase

        unique case (cnt)
            2'd1:    rec[0].last_of_run = 1'b1;
            2'd2:    rec[1].last_of_run = 1'b1;
            2'd3:    rec[2].last_of_run = 1'b1;
            default: ;
        endcase

        if (i_eod) begin
            mode = jpp_pkg::MODE_NORMAL;
            ind  = i_start_indent;
        end
    end

    assign o_rec         = rec;
    assign o_step.mode   = mode;
    assign o_step.indent = ind;
    assign o_step.count  = cnt;

endmodule
